[hw/rtl/lpkf_pkg.sv]
// ----------------------------------------------------------------------------
// lpkf_pkg
// Types and constants shared by the key-to-flags cache modules.
// ----------------------------------------------------------------------------
package lpkf_pkg;

   localparam int KEY_W = 64;
   localparam int SLOT_IDX_W = 9;
   localparam logic [KEY_W-1:0] GOLDEN_MULT = 64'h9E37_79B9_7F4A_7C15;

   localparam logic KIND_LOOKUP = 1'b0;
   localparam logic KIND_INSERT = 1'b1;

   typedef struct packed {
      logic patched;
      logic large_icon;
      logic small_icon;
   } lpkf_flags_type;

   typedef struct packed {
      logic           occupied;
      lpkf_flags_type flags;
      logic [KEY_W-1:0] key;
   } lpkf_entry_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH,
      ST_PROBE
   } lpkf_state_type;

endpackage

[hw/rtl/lpkf_ram.sv]
// ----------------------------------------------------------------------------
// lpkf_ram
// Single-port synchronous RAM with a registered read port.
// ----------------------------------------------------------------------------
module lpkf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

[hw/rtl/lpkf_hash.sv]
// ----------------------------------------------------------------------------
// lpkf_hash
// Four-stage Fibonacci hash pipeline: the key times the golden-ratio constant
// modulo 2^64, scaled to the table size to give the home slot.
// ----------------------------------------------------------------------------
module lpkf_hash #(
   parameter int TABLE_SLOTS = 512
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [lpkf_pkg::KEY_W-1:0]     key,
   output logic                           valid,
   output logic [$clog2(TABLE_SLOTS)-1:0] home
);
   import lpkf_pkg::*;

   localparam int SLOT_W = $clog2(TABLE_SLOTS);
   localparam int NW = $clog2(TABLE_SLOTS + 1);
   localparam logic [NW-1:0] SLOTS_N = NW'(TABLE_SLOTS);

   logic [3:0]         vld_ff;
   logic [63:0]        ll_ff;
   logic [31:0]        hl_ff;
   logic [31:0]        lh_ff;
   logic [63:0]        h_ff;
   logic [32+NW-1:0]   hin_ff;
   logic [32+NW-1:0]   lon_ff;
   logic [SLOT_W-1:0]  home_ff;

   logic [63:0]        ll_in;
   logic [63:0]        hl_full;
   logic [63:0]        lh_full;
   logic [63:0]        h_in;
   logic [32+NW-1:0]   hin_in;
   logic [32+NW-1:0]   lon_in;
   logic [32+NW:0]     sum;

   assign ll_in   = key[31:0] * GOLDEN_MULT[31:0];
   assign hl_full = key[63:32] * GOLDEN_MULT[31:0];
   assign lh_full = key[31:0] * GOLDEN_MULT[63:32];
   assign h_in    = ll_ff + {hl_ff + lh_ff, 32'd0};
   assign hin_in  = h_ff[63:32] * SLOTS_N;
   assign lon_in  = h_ff[31:0] * SLOTS_N;
   assign sum     = {1'b0, hin_ff} + (33+NW)'(lon_ff[32+NW-1:32]);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[2:0], start};
      end
      ll_ff   <= ll_in;
      hl_ff   <= hl_full[31:0];
      lh_ff   <= lh_full[31:0];
      h_ff    <= h_in;
      hin_ff  <= hin_in;
      lon_ff  <= lon_in;
      home_ff <= sum[32 +: SLOT_W];
   end

   assign valid = vld_ff[3];
   assign home  = home_ff;

endmodule

[hw/rtl/linear_probe_key_flag_cache_core.sv]
// ----------------------------------------------------------------------------
// linear_probe_key_flag_cache_core
// Key-to-flags cache in an open-addressed table with linear probing.
//
//   Channel   Handshake            Ports
//   request   start & !busy        req_kind, req_key, req_large_icon_wanted,
//                                  req_new_small_icon, req_new_large_icon,
//                                  req_new_config_patched
//   response  rsp_valid, 1 cycle   rsp_found, rsp_slot_index, rsp_full_overwrite,
//                                  rsp_config_flag, rsp_small_icon_flag,
//                                  rsp_large_icon_flag, rsp_chosen_icon,
//                                  rsp_nothing_to_do
//
// After acceptance a transaction passes through the hash pipeline, then the
// table memory is read once per probed slot, from 1 to TABLE_SLOTS slots,
// before the response strobe. After reset the block stays busy while it clears
// the occupied marks of all TABLE_SLOTS slots, one slot per cycle.
// The response cannot be stalled; busy drops in the cycle the strobe is shown.
// ----------------------------------------------------------------------------
module linear_probe_key_flag_cache_core #(
   parameter int TABLE_SLOTS = 512
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_kind,
   input  logic [lpkf_pkg::KEY_W-1:0]        req_key,
   input  logic                              req_large_icon_wanted,
   input  logic                              req_new_small_icon,
   input  logic                              req_new_large_icon,
   input  logic                              req_new_config_patched,
   output logic                              rsp_valid,
   output logic                              rsp_found,
   output logic [lpkf_pkg::SLOT_IDX_W-1:0]   rsp_slot_index,
   output logic                              rsp_full_overwrite,
   output logic                              rsp_config_flag,
   output logic                              rsp_small_icon_flag,
   output logic                              rsp_large_icon_flag,
   output logic                              rsp_chosen_icon,
   output logic                              rsp_nothing_to_do
);
   import lpkf_pkg::*;

   localparam int SLOT_W = $clog2(TABLE_SLOTS);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SLOTS - 1);
   localparam int ENTRY_W = $bits(lpkf_entry_type);

   lpkf_state_type    state_ff, state_in;
   logic [SLOT_W-1:0] clr_cnt_ff, clr_cnt_in;
   logic              kind_ff;
   logic [KEY_W-1:0]  key_ff;
   logic              want_large_ff;
   lpkf_flags_type    new_flags_ff;
   logic [SLOT_W-1:0] pos_ff, pos_in;
   logic [SLOT_W-1:0] home_ff, home_in;
   logic [SLOT_W-1:0] cnt_ff, cnt_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              found_ff, found_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic              overwrite_ff, overwrite_in;
   lpkf_flags_type    flags_ff, flags_in;
   logic              want_ff, want_in;
   logic              idle_ff, idle_in;

   logic              accept;
   logic              hash_valid;
   logic [SLOT_W-1:0] hash_home;

   logic              ram_we;
   logic [SLOT_W-1:0] ram_addr;
   lpkf_entry_type    ram_wdata;
   lpkf_entry_type    ram_rdata;

   logic              probe_empty;
   logic              probe_match;
   logic              probe_done;
   logic [SLOT_W-1:0] next_pos;
   logic [SLOT_W-1:0] stop_slot;
   lpkf_flags_type    res_flags;
   logic              res_want;

   assign accept = start && (state_ff == ST_IDLE);

   lpkf_hash #(
      .TABLE_SLOTS(TABLE_SLOTS)
   ) u_hash (
      .clock(clock),
      .reset(reset),
      .start(accept),
      .key  (req_key),
      .valid(hash_valid),
      .home (hash_home)
   );

   lpkf_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(TABLE_SLOTS)
   ) u_table (
      .clock(clock),
      .we   (ram_we),
      .addr (ram_addr),
      .wdata(ram_wdata),
      .rdata(ram_rdata)
   );

   assign probe_empty = !ram_rdata.occupied;
   assign probe_match = ram_rdata.occupied && (ram_rdata.key == key_ff);
   assign probe_done  = probe_empty || probe_match || (cnt_ff == LAST_SLOT);
   assign next_pos    = (pos_ff == LAST_SLOT) ? '0 : pos_ff + 1'b1;
   assign stop_slot   = (probe_empty || probe_match) ? pos_ff : home_ff;

   always_comb begin
      if (kind_ff == KIND_INSERT) begin
         res_flags = new_flags_ff;
      end else if (probe_match) begin
         res_flags = ram_rdata.flags;
      end else begin
         res_flags = '0;
      end
      res_want = want_large_ff ? res_flags.large_icon : res_flags.small_icon;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_cnt_ff == LAST_SLOT) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               state_in = ST_HASH;
            end
         end
         ST_HASH: begin
            if (hash_valid) begin
               state_in = ST_PROBE;
            end
         end
         ST_PROBE: begin
            if (probe_done) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // Outputs and datapath next values.
   always_comb begin
      busy         = (state_ff != ST_IDLE);
      ram_we       = 1'b0;
      ram_addr     = pos_ff;
      ram_wdata    = '0;
      clr_cnt_in   = clr_cnt_ff;
      pos_in       = pos_ff;
      home_in      = home_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = 1'b0;
      found_in     = found_ff;
      slot_in      = slot_ff;
      overwrite_in = overwrite_ff;
      flags_in     = flags_ff;
      want_in      = want_ff;
      idle_in      = idle_ff;
      case (state_ff)
         ST_CLEAR: begin
            ram_we     = 1'b1;
            ram_addr   = clr_cnt_ff;
            clr_cnt_in = clr_cnt_ff + 1'b1;
         end
         ST_IDLE: begin
         end
         ST_HASH: begin
            ram_addr = hash_home;
            if (hash_valid) begin
               pos_in  = hash_home;
               home_in = hash_home;
               cnt_in  = '0;
            end
         end
         ST_PROBE: begin
            if (probe_done) begin
               rsp_valid_in = 1'b1;
               found_in     = probe_match;
               slot_in      = stop_slot;
               overwrite_in = (kind_ff == KIND_INSERT) && !probe_empty && !probe_match;
               flags_in     = res_flags;
               want_in      = res_want;
               idle_in      = (kind_ff == KIND_LOOKUP) && probe_match
                              && !res_flags.patched && !res_want;
               if (kind_ff == KIND_INSERT) begin
                  ram_we             = 1'b1;
                  ram_addr           = stop_slot;
                  ram_wdata.occupied = 1'b1;
                  ram_wdata.flags    = new_flags_ff;
                  ram_wdata.key      = key_ff;
               end
            end else begin
               ram_addr = next_pos;
               pos_in   = next_pos;
               cnt_in   = cnt_ff + 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) begin
         kind_ff                 <= req_kind;
         key_ff                  <= req_key;
         want_large_ff           <= req_large_icon_wanted;
         new_flags_ff.small_icon <= req_new_small_icon;
         new_flags_ff.large_icon <= req_new_large_icon;
         new_flags_ff.patched    <= req_new_config_patched;
      end
      pos_ff       <= pos_in;
      home_ff      <= home_in;
      cnt_ff       <= cnt_in;
      found_ff     <= found_in;
      slot_ff      <= slot_in;
      overwrite_ff <= overwrite_in;
      flags_ff     <= flags_in;
      want_ff      <= want_in;
      idle_ff      <= idle_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_found          = found_ff;
   assign rsp_slot_index     = SLOT_IDX_W'(slot_ff);
   assign rsp_full_overwrite = overwrite_ff;
   assign rsp_config_flag    = flags_ff.patched;
   assign rsp_small_icon_flag = flags_ff.small_icon;
   assign rsp_large_icon_flag = flags_ff.large_icon;
   assign rsp_chosen_icon    = want_ff;
   assign rsp_nothing_to_do  = idle_ff;

   a_rsp_only_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == ST_IDLE))
      else $error("response strobe outside the idle state");

   a_accept_starts_hash: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_HASH))
      else $error("accepted transaction did not enter the hash state");

   a_hash_valid_in_hash: assert property (@(posedge clock) disable iff (reset)
      hash_valid |-> (state_ff == ST_HASH))
      else $error("hash result arrived outside the hash state");

   a_probe_write_insert: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_PROBE) && ram_we) |-> (kind_ff == KIND_INSERT) && probe_done)
      else $error("table written by a lookup or before probing ended");

   a_probe_response: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_PROBE) && probe_done) |=> rsp_valid_ff)
      else $error("finished probe gave no response");

endmodule
